// ===== sv/bvc_pkg.sv =====
// ----------------------------------------------------------------------------
// bvc_pkg: shared types and constants for barometric compensation
// Payload structs, controller and multiplier states, word widths and the
// fixed constants of the compensation formulas.
// ----------------------------------------------------------------------------
package bvc_pkg;

    // sample and calibration widths
    localparam int RAW_W      = 20;
    localparam int ADC_BITS   = 20;
    localparam int CAL_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int VALUE_W    = 32;

    // mask on the raw sample, low ADC_BITS bits of the 20-bit field
    localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << ADC_BITS) - 64'd1);

    // calibration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C   = 2'd3;
    localparam int                   CFG_REGS      = 4;

    // shared multiplier geometry: 32x32 limb products
    localparam int MUL_LIMB_W  = 32;
    localparam int MUL_A_LIMBS = 5;
    localparam int MUL_B_LIMBS = 3;
    localparam int MUL_A_W     = MUL_LIMB_W * MUL_A_LIMBS;
    localparam int MUL_B_W     = MUL_LIMB_W * MUL_B_LIMBS;
    localparam int WIDE_W      = 192;
    localparam int MUL_SH_W    = WIDE_W + 2 * MUL_LIMB_W;

    // formula constants
    localparam int E_W        = 33;
    localparam int D_W        = 22;
    localparam int FT_W       = 32;
    localparam int FT_OFFSET  = 128000;
    localparam int M_SCALE    = 6250;
    localparam int DIV_BITS   = 33;
    localparam int DIV_CNT_W  = 6;

    typedef struct packed {
        logic             kind;
        logic [RAW_W-1:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic                      result_kind;
        logic signed [VALUE_W-1:0] value;
        logic                      divide_error;
        logic                      saturated;
    } out_item_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_DRAIN,
        MUL_SIGN
    } mul_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_DD,
        ST_T_DDC3,
        ST_T_DC2,
        ST_T_SUM,
        ST_T_OUT,
        ST_P_EE,
        ST_P_EEP3,
        ST_P_EP2,
        ST_P_Q,
        ST_P_EEP6,
        ST_P_EP5,
        ST_P_M,
        ST_P_M6250,
        ST_P_B,
        ST_P_MB,
        ST_P_MBP8,
        ST_P_N1,
        ST_P_MM,
        ST_P_MMP9,
        ST_P_N2,
        ST_P_BB,
        ST_P_BBP7,
        ST_P_N3,
        ST_P_DIVSET,
        ST_P_DIVCHK,
        ST_P_DIV,
        ST_P_FIN,
        ST_EMIT
    } ctrl_state_t;

endpackage

// ===== sv/bvc_mul.sv =====
// ----------------------------------------------------------------------------
// bvc_mul: shared signed multi-limb multiplier
// Multiplies magnitudes one 32x32 limb product per cycle, accumulates the
// registered partial products and applies the sign at the end.
// ----------------------------------------------------------------------------
module bvc_mul import bvc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic                      done,
    output logic signed [WIDE_W-1:0]  mul_prod
);

    mul_state_t state_reg, state_next;

    logic [MUL_A_W-1:0]      a_mag_reg;
    logic [MUL_B_W-1:0]      b_mag_reg;
    logic                    neg_reg;
    logic [2:0]              ia_reg;
    logic [1:0]              ib_reg;
    logic [2*MUL_LIMB_W-1:0] pp_reg;
    logic [2:0]              pk_reg;
    logic                    pp_vld_reg;
    logic [WIDE_W-1:0]       acc_reg;
    logic signed [WIDE_W-1:0] prod_reg;
    logic                    done_reg;

    logic                    last_a;
    logic                    last_b;
    logic [MUL_SH_W-1:0]     pp_shift;

    assign last_a   = (ia_reg == 3'(MUL_A_LIMBS - 1));
    assign last_b   = (ib_reg == 2'(MUL_B_LIMBS - 1));
    assign pp_shift = {{(MUL_SH_W - 2*MUL_LIMB_W){1'b0}}, pp_reg} << {pk_reg, 5'd0};

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MUL_IDLE: begin
                if (start) begin
                    state_next = MUL_RUN;
                end
            end
            MUL_RUN: begin
                if (last_a && last_b) begin
                    state_next = MUL_DRAIN;
                end
            end
            MUL_DRAIN: state_next = MUL_SIGN;
            MUL_SIGN:  state_next = MUL_IDLE;
            default:   state_next = MUL_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= MUL_IDLE;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pp_vld_reg <= (state_reg == MUL_RUN);
            done_reg   <= (state_reg == MUL_SIGN);
        end
    end

    // operand magnitudes, limb products and accumulation
    always_ff @(posedge aclk) begin
        case (state_reg)
            MUL_IDLE: begin
                a_mag_reg <= op_a[MUL_A_W-1] ? MUL_A_W'(-op_a) : MUL_A_W'(op_a);
                b_mag_reg <= op_b[MUL_B_W-1] ? MUL_B_W'(-op_b) : MUL_B_W'(op_b);
                neg_reg   <= op_a[MUL_A_W-1] ^ op_b[MUL_B_W-1];
                ia_reg    <= '0;
                ib_reg    <= '0;
                acc_reg   <= '0;
            end
            MUL_RUN: begin
                pp_reg <= a_mag_reg[ia_reg*MUL_LIMB_W +: MUL_LIMB_W]
                        * b_mag_reg[ib_reg*MUL_LIMB_W +: MUL_LIMB_W];
                pk_reg <= ia_reg + 3'(ib_reg);
                if (last_b) begin
                    ib_reg <= '0;
                    ia_reg <= ia_reg + 3'd1;
                end else begin
                    ib_reg <= ib_reg + 2'd1;
                end
                if (pp_vld_reg) begin
                    acc_reg <= acc_reg + pp_shift[WIDE_W-1:0];
                end
            end
            MUL_DRAIN: begin
                acc_reg <= acc_reg + pp_shift[WIDE_W-1:0];
            end
            MUL_SIGN: begin
                prod_reg <= neg_reg ? $signed(-acc_reg) : $signed(acc_reg);
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign mul_prod = prod_reg;

endmodule

// ===== sv/baro_temp_pressure_compensation_top.sv =====
// Each multiply runs on the shared 32x32 limb multiplier; a pressure item ends
// early on a zero divisor and skips the divide when the quotient overflows,
// else the final divide yields one quotient bit a cycle. An item is taken only
// when idle, after the previous one has been emitted; the next item is taken
// while a result still waits in the output register. Reset clears calibration
// and fine temperature.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top: temperature and pressure compensation
// Sequencer over one shared multiplier evaluates the exact polynomial forms,
// then a restoring divider floors the pressure ratio and saturates to 32 bits.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top import bvc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_wdata
);

    ctrl_state_t state_reg, state_next;
    logic        issued_reg, issued_next;

    logic [CAL_W-1:0]        cal_reg [CFG_REGS];
    logic signed [FT_W-1:0]  ft_reg;

    logic                    kind_reg;
    logic [RAW_W-1:0]        raw_reg;
    logic signed [D_W-1:0]   d_reg;
    logic signed [E_W-1:0]   e_reg;
    logic signed [WIDE_W-1:0] ra_reg, rb_reg, rc_reg, rd_reg, rn_reg;
    logic signed [63:0]      rq_reg;
    logic signed [MUL_B_W-1:0] rm_reg;
    logic [WIDE_W-1:0]       rr_reg, dsh_reg;
    logic [DIV_BITS-1:0]     quo_reg;
    logic                    neg_reg, big_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;

    logic signed [VALUE_W-1:0] res_value_reg;
    logic                    res_sat_reg, res_derr_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    // multiplier hookup
    logic                      mul_start, mul_done, is_mul;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [WIDE_W-1:0]  mul_prod;
    ctrl_state_t               mul_follow;

    // calibration word slices
    logic [15:0]        c1, p1;
    logic signed [15:0] c2, c3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [RAW_W-1:0]   raw_m;

    // intermediate arithmetic
    logic signed [63:0]  q_calc, num2_calc, m_calc, n_calc;
    logic [RAW_W:0]      span_diff;
    logic                derr_cond;
    logic signed [63:0]  n64, five_n, tval;
    logic [63:0]         n_abs, tr_mag;
    logic [FT_W-1:0]     ft_calc;
    logic [WIDE_W-1:0]   dlim, rn_abs;
    logic                big_calc, div_ge, rem_nz;
    logic [DIV_BITS:0]   qm;

    assign c1 = cal_reg[CFG_TEMP_CAL][15:0];
    assign c2 = cal_reg[CFG_TEMP_CAL][31:16];
    assign c3 = cal_reg[CFG_TEMP_CAL][47:32];
    assign p1 = cal_reg[CFG_PRESS_A][15:0];
    assign p2 = cal_reg[CFG_PRESS_A][31:16];
    assign p3 = cal_reg[CFG_PRESS_A][47:32];
    assign p4 = cal_reg[CFG_PRESS_B][15:0];
    assign p5 = cal_reg[CFG_PRESS_B][31:16];
    assign p6 = cal_reg[CFG_PRESS_B][47:32];
    assign p7 = cal_reg[CFG_PRESS_C][15:0];
    assign p8 = cal_reg[CFG_PRESS_C][31:16];
    assign p9 = cal_reg[CFG_PRESS_C][47:32];

    assign raw_m = s_data.raw_sample & RAW_MASK;

    // temperature sum n = d*c2*2^20 + d*d*c3
    assign n_calc = $signed(rb_reg[63:0] << 20) + $signed(ra_reg[63:0]);

    // pressure divisor term q = 2^55 + p3*e*e + p2*e*2^20
    assign q_calc = (64'sd1 <<< 55) + $signed(ra_reg[63:0]) + $signed(rb_reg[63:0] << 20);
    assign derr_cond = (p1 == 16'd0) || (q_calc == 64'sd0);

    // numerator offset m = (2^20 - raw)*2^31 - num2
    assign span_diff = (21'd1 << RAW_W) - {1'b0, raw_reg};
    assign num2_calc = $signed(ra_reg[63:0]) + $signed(rb_reg[63:0] << 17)
                     + (64'(p4) <<< 35);
    assign m_calc    = $signed(64'(span_diff) << 31) - num2_calc;

    // temperature result and truncated fine temperature
    assign n64     = rn_reg[63:0];
    assign n_abs   = n64[63] ? 64'(-n64) : 64'(n64);
    assign tr_mag  = n_abs >> 34;
    assign ft_calc = n64[63] ? 32'(64'd0 - tr_mag) : 32'(tr_mag);
    assign five_n  = (n64 <<< 2) + n64;
    assign tval    = five_n >>> 42;

    // divider compare values
    assign rn_abs   = rn_reg[WIDE_W-1] ? WIDE_W'(-rn_reg) : WIDE_W'(rn_reg);
    assign dlim     = rd_reg << DIV_BITS;
    assign big_calc = (rr_reg >= dlim);
    assign div_ge   = (rr_reg >= dsh_reg);
    assign rem_nz   = (rr_reg != '0);
    assign qm       = {1'b0, quo_reg} + {{DIV_BITS{1'b0}}, rem_nz};

    bvc_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .done     (mul_done),
        .mul_prod (mul_prod)
    );

    // sequencer next state and multiplier operand select
    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        is_mul      = 1'b0;
        mul_follow  = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_data.kind ? ST_P_EE : ST_T_DD;
                end
            end
            ST_T_DD: begin
                is_mul = 1'b1; mul_follow = ST_T_DDC3;
                mul_a = MUL_A_W'(d_reg); mul_b = MUL_B_W'(d_reg);
            end
            ST_T_DDC3: begin
                is_mul = 1'b1; mul_follow = ST_T_DC2;
                mul_a = ra_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(c3);
            end
            ST_T_DC2: begin
                is_mul = 1'b1; mul_follow = ST_T_SUM;
                mul_a = MUL_A_W'(d_reg); mul_b = MUL_B_W'(c2);
            end
            ST_T_SUM: state_next = ST_T_OUT;
            ST_T_OUT: state_next = ST_EMIT;
            ST_P_EE: begin
                is_mul = 1'b1; mul_follow = ST_P_EEP3;
                mul_a = MUL_A_W'(e_reg); mul_b = MUL_B_W'(e_reg);
            end
            ST_P_EEP3: begin
                is_mul = 1'b1; mul_follow = ST_P_EP2;
                mul_a = rc_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(p3);
            end
            ST_P_EP2: begin
                is_mul = 1'b1; mul_follow = ST_P_Q;
                mul_a = MUL_A_W'(e_reg); mul_b = MUL_B_W'(p2);
            end
            ST_P_Q: state_next = derr_cond ? ST_EMIT : ST_P_EEP6;
            ST_P_EEP6: begin
                is_mul = 1'b1; mul_follow = ST_P_EP5;
                mul_a = rc_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(p6);
            end
            ST_P_EP5: begin
                is_mul = 1'b1; mul_follow = ST_P_M;
                mul_a = MUL_A_W'(e_reg); mul_b = MUL_B_W'(p5);
            end
            ST_P_M: state_next = ST_P_M6250;
            ST_P_M6250: begin
                is_mul = 1'b1; mul_follow = ST_P_B;
                mul_a = MUL_A_W'(rm_reg); mul_b = MUL_B_W'(M_SCALE);
            end
            ST_P_B: begin
                is_mul = 1'b1; mul_follow = ST_P_MB;
                mul_a = MUL_A_W'(rq_reg); mul_b = MUL_B_W'(p1);
            end
            ST_P_MB: begin
                is_mul = 1'b1; mul_follow = ST_P_MBP8;
                mul_a = MUL_A_W'(rm_reg); mul_b = rb_reg[MUL_B_W-1:0];
            end
            ST_P_MBP8: begin
                is_mul = 1'b1; mul_follow = ST_P_N1;
                mul_a = ra_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(p8);
            end
            ST_P_N1: state_next = ST_P_MM;
            ST_P_MM: begin
                is_mul = 1'b1; mul_follow = ST_P_MMP9;
                mul_a = MUL_A_W'(rm_reg); mul_b = rm_reg;
            end
            ST_P_MMP9: begin
                is_mul = 1'b1; mul_follow = ST_P_N2;
                mul_a = ra_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(p9);
            end
            ST_P_N2: state_next = ST_P_BB;
            ST_P_BB: begin
                is_mul = 1'b1; mul_follow = ST_P_BBP7;
                mul_a = rb_reg[MUL_A_W-1:0]; mul_b = rb_reg[MUL_B_W-1:0];
            end
            ST_P_BBP7: begin
                is_mul = 1'b1; mul_follow = ST_P_N3;
                mul_a = rd_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(p7);
            end
            ST_P_N3:     state_next = ST_P_DIVSET;
            ST_P_DIVSET: state_next = ST_P_DIVCHK;
            ST_P_DIVCHK: state_next = big_calc ? ST_P_FIN : ST_P_DIV;
            ST_P_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_P_FIN;
                end
            end
            ST_P_FIN: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // multiply steps: launch once, advance when the product is back
        if (is_mul) begin
            if (!issued_reg) begin
                mul_start   = 1'b1;
                issued_next = 1'b1;
            end else if (mul_done) begin
                issued_next = 1'b0;
                state_next  = mul_follow;
            end
        end
    end

    // control state, calibration, fine temperature and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            ft_reg      <= '0;
            for (int i = 0; i < CFG_REGS; i++) begin
                cal_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            if (cfg_wr_en) begin
                cal_reg[cfg_index] <= cfg_wdata;
            end
            if (state_reg == ST_T_OUT) begin
                ft_reg <= ft_calc;
            end
            if (state_reg == ST_EMIT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            kind_reg <= s_data.kind;
            raw_reg  <= raw_m;
            d_reg    <= $signed({2'b00, raw_m}) - $signed({2'b00, c1, 4'b0000});
            e_reg    <= E_W'(ft_reg) - E_W'(FT_OFFSET);
        end

        // multiplier write-back
        if (mul_done && issued_reg) begin
            case (state_reg)
                ST_T_DD, ST_T_DDC3, ST_P_EEP3, ST_P_EEP6, ST_P_MB, ST_P_MM: begin
                    ra_reg <= mul_prod;
                end
                ST_T_DC2, ST_P_EP2, ST_P_EP5, ST_P_B: begin
                    rb_reg <= mul_prod;
                end
                ST_P_EE, ST_P_MBP8, ST_P_MMP9, ST_P_BBP7: begin
                    rc_reg <= mul_prod;
                end
                ST_P_BB:    rd_reg <= mul_prod;
                ST_P_M6250: rm_reg <= mul_prod[MUL_B_W-1:0];
                default:    rd_reg <= rd_reg;
            endcase
        end

        // add, divide and result steps
        case (state_reg)
            ST_T_SUM: rn_reg <= WIDE_W'(n_calc);
            ST_T_OUT: begin
                res_derr_reg <= 1'b0;
                if (tval > 64'sd2147483647) begin
                    res_value_reg <= 32'sh7FFFFFFF;
                    res_sat_reg   <= 1'b1;
                end else if (tval < -64'sd2147483648) begin
                    res_value_reg <= 32'sh80000000;
                    res_sat_reg   <= 1'b1;
                end else begin
                    res_value_reg <= tval[VALUE_W-1:0];
                    res_sat_reg   <= 1'b0;
                end
            end
            ST_P_Q: begin
                rq_reg        <= q_calc;
                res_value_reg <= '0;
                res_derr_reg  <= derr_cond;
                res_sat_reg   <= 1'b0;
            end
            ST_P_M:  rm_reg <= MUL_B_W'(m_calc);
            ST_P_N1: rn_reg <= (ra_reg <<< 32) + (rc_reg <<< 13);
            ST_P_N2: rn_reg <= rn_reg + (rc_reg <<< 21);
            ST_P_N3: rn_reg <= rn_reg + (rc_reg <<< 4);
            ST_P_DIVSET: begin
                rr_reg  <= rn_abs;
                neg_reg <= rn_reg[WIDE_W-1];
                dsh_reg <= rd_reg << (DIV_BITS - 1);
                cnt_reg <= DIV_CNT_W'(DIV_BITS - 1);
                quo_reg <= '0;
            end
            ST_P_DIVCHK: big_reg <= big_calc;
            ST_P_DIV: begin
                if (div_ge) begin
                    rr_reg <= rr_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[DIV_BITS-2:0], div_ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_P_FIN: begin
                res_derr_reg <= 1'b0;
                if (!neg_reg) begin
                    if (big_reg || quo_reg[DIV_BITS-1] || quo_reg[VALUE_W-1]) begin
                        res_value_reg <= 32'sh7FFFFFFF;
                        res_sat_reg   <= 1'b1;
                    end else begin
                        res_value_reg <= $signed(quo_reg[VALUE_W-1:0]);
                        res_sat_reg   <= 1'b0;
                    end
                end else begin
                    if (big_reg || qm > (34'd1 << (VALUE_W - 1))) begin
                        res_value_reg <= 32'sh80000000;
                        res_sat_reg   <= 1'b1;
                    end else begin
                        res_value_reg <= $signed(VALUE_W'(34'd0 - qm));
                        res_sat_reg   <= 1'b0;
                    end
                end
            end
            default: begin
                rn_reg <= rn_reg;
            end
        endcase

        // output payload, loaded when the slot is free
        if (state_reg == ST_EMIT && (!m_valid_reg || m_ready)) begin
            m_data_reg.result_kind  <= kind_reg;
            m_data_reg.value        <= res_value_reg;
            m_data_reg.divide_error <= res_derr_reg;
            m_data_reg.saturated    <= res_sat_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== dv/tb_baro_temp_pressure_compensation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation_top: self-checking bench
// Drives temperature and pressure samples through the valid/ready input,
// predicts every result with an exact wide-integer model of the compensation
// formulas and compares each output transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensation_top;
    import bvc_pkg::*;

    typedef logic signed [255:0] wide_int_t;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    // typical calibration set of this sensor family
    localparam logic [15:0] TYP_C1 = 16'd27504;
    localparam logic [15:0] TYP_C2 = 16'd26435;
    localparam logic [15:0] TYP_C3 = -16'sd1000;
    localparam logic [15:0] TYP_P1 = 16'd36477;
    localparam logic [15:0] TYP_P2 = -16'sd10685;
    localparam logic [15:0] TYP_P3 = 16'd3024;
    localparam logic [15:0] TYP_P4 = 16'd2855;
    localparam logic [15:0] TYP_P5 = 16'd140;
    localparam logic [15:0] TYP_P6 = -16'sd7;
    localparam logic [15:0] TYP_P7 = 16'd15500;
    localparam logic [15:0] TYP_P8 = -16'sd14600;
    localparam logic [15:0] TYP_P9 = 16'd6000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAL_W-1:0]     cfg_wdata = '0;

    // predictor state
    logic [CAL_W-1:0]     cal_regs [CFG_REGS];
    logic signed [31:0]   fine_temp;
    out_item_t            expected_results [$];

    int  error_count;
    int  temp_seen, press_seen, div_err_seen, sat_seen;
    bit  ready_steady;
    int  stall_left;

    baro_temp_pressure_compensation_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // exact compensation of one sample, updates fine temperature
    function automatic out_item_t compensate(in_item_t it);
        out_item_t   r;
        longint      one, raw, c1, c2, c3, d, n, tr, v;
        longint      p1, p2, p3, p4, p5, p6, p7, p8, p9, e, q, num2, m;
        wide_int_t   a, b, ab, num, den, quot, rem;
        one = 1;
        raw = longint'(it.raw_sample & RAW_MASK);
        r = '0;
        r.result_kind = it.kind;
        if (it.kind == KIND_TEMP) begin
            c1 = longint'(cal_regs[CFG_TEMP_CAL][15:0]);
            c2 = longint'($signed(cal_regs[CFG_TEMP_CAL][31:16]));
            c3 = longint'($signed(cal_regs[CFG_TEMP_CAL][47:32]));
            d = raw - 16 * c1;
            n = d * c2 * (one <<< 20) + d * d * c3;
            tr = n / (one <<< 34);
            fine_temp = tr[31:0];
            v = (5 * n) >>> 42;
            if (v > 64'sd2147483647) begin
                v = 64'sd2147483647;
                r.saturated = 1'b1;
            end else if (v < -64'sd2147483648) begin
                v = -64'sd2147483648;
                r.saturated = 1'b1;
            end
            r.value = v[31:0];
        end else begin
            p1 = longint'(cal_regs[CFG_PRESS_A][15:0]);
            p2 = longint'($signed(cal_regs[CFG_PRESS_A][31:16]));
            p3 = longint'($signed(cal_regs[CFG_PRESS_A][47:32]));
            p4 = longint'($signed(cal_regs[CFG_PRESS_B][15:0]));
            p5 = longint'($signed(cal_regs[CFG_PRESS_B][31:16]));
            p6 = longint'($signed(cal_regs[CFG_PRESS_B][47:32]));
            p7 = longint'($signed(cal_regs[CFG_PRESS_C][15:0]));
            p8 = longint'($signed(cal_regs[CFG_PRESS_C][31:16]));
            p9 = longint'($signed(cal_regs[CFG_PRESS_C][47:32]));
            e = longint'(fine_temp) - 128000;
            q = (one <<< 55) + p3 * e * e + p2 * e * (one <<< 20);
            if (p1 == 0 || q == 0) begin
                r.divide_error = 1'b1;
                r.value = '0;
            end else begin
                num2 = e * e * p6 + e * p5 * (one <<< 17) + p4 * (one <<< 35);
                m = ((one <<< 20) - raw) * (one <<< 31) - num2;
                a = wide_int_t'(m) * wide_int_t'(6250 * (one <<< 24));
                b = wide_int_t'(p1) * wide_int_t'(q);
                // keep the divisor positive
                if (b < 0) begin
                    b = -b;
                    a = -a;
                end
                ab = a * b;
                num = ab * (wide_int_t'(1) <<< 43)
                    + a * a * wide_int_t'(256 * p9)
                    + ab * wide_int_t'(p8 * (one <<< 24))
                    + b * b * wide_int_t'(p7 * (one <<< 39));
                den = b * b * (wide_int_t'(1) <<< 35);
                quot = num / den;
                rem = num % den;
                if (num < 0 && rem != 0)
                    quot = quot - 1;
                if (quot > wide_int_t'(64'sd2147483647)) begin
                    quot = wide_int_t'(64'sd2147483647);
                    r.saturated = 1'b1;
                end else if (quot < wide_int_t'(-64'sd2147483648)) begin
                    quot = wide_int_t'(-64'sd2147483648);
                    r.saturated = 1'b1;
                end
                r.value = quot[31:0];
            end
        end
        return r;
    endfunction

    // one input transfer, expectation queued once accepted
    task automatic send_sample(logic kind, logic [RAW_W-1:0] raw);
        in_item_t it;
        int       gap, pick;
        it.kind = kind;
        it.raw_sample = raw;
        pick = $urandom_range(99);
        gap = (pick < 60) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(compensate(it));
    endtask

    // drop valid and drain every pending result
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cal_regs[idx] = val;
    endtask

    task automatic write_all_cal(logic [CAL_W-1:0] t, logic [CAL_W-1:0] pa,
                                 logic [CAL_W-1:0] pb, logic [CAL_W-1:0] pc);
        write_cal(CFG_TEMP_CAL, t);
        write_cal(CFG_PRESS_A, pa);
        write_cal(CFG_PRESS_B, pb);
        write_cal(CFG_PRESS_C, pc);
    endtask

    function automatic logic [15:0] jitter(logic [15:0] w, int span);
        return w + 16'($urandom_range(2 * span) - span);
    endfunction

    task automatic load_typical_cal(int span);
        write_all_cal({jitter(TYP_C3, span), jitter(TYP_C2, span), jitter(TYP_C1, span)},
                      {jitter(TYP_P3, span), jitter(TYP_P2, span), jitter(TYP_P1, span)},
                      {jitter(TYP_P6, span), jitter(TYP_P5, span), jitter(TYP_P4, span)},
                      {jitter(TYP_P9, span), jitter(TYP_P8, span), jitter(TYP_P7, span)});
    endtask

    // pressure right after reset, zero calibration and fine temperature zero
    task automatic test_after_reset();
        send_sample(KIND_PRESS, 20'd415148);
        wait_idle();
        load_typical_cal(0);
        send_sample(KIND_PRESS, 20'd415148);
        send_sample(KIND_TEMP, 20'd519888);
        send_sample(KIND_PRESS, 20'd415148);
        wait_idle();
    endtask

    // field extremes on both kinds
    task automatic test_extremes();
        send_sample(KIND_TEMP, '0);
        send_sample(KIND_PRESS, '0);
        send_sample(KIND_PRESS, '1);
        send_sample(KIND_TEMP, '1);
        send_sample(KIND_PRESS, '0);
        send_sample(KIND_PRESS, '1);
        wait_idle();
        write_all_cal('1, '1, '1, '1);
        send_sample(KIND_TEMP, '1);
        send_sample(KIND_PRESS, '0);
        send_sample(KIND_TEMP, '0);
        send_sample(KIND_PRESS, '1);
        wait_idle();
        // most negative signed words, largest unsigned words, largest positive p7 to p9
        write_all_cal({16'h8000, 16'h8000, 16'hffff}, {16'h8000, 16'h8000, 16'hffff},
                      {16'h8000, 16'h8000, 16'h8000}, {16'h7fff, 16'h7fff, 16'h7fff});
        send_sample(KIND_TEMP, 20'h80000);
        send_sample(KIND_PRESS, 20'h7ffff);
        send_sample(KIND_TEMP, '1);
        send_sample(KIND_PRESS, '0);
        wait_idle();
    endtask

    // zero divisor through p1 zero and through the linear p2 term cancelling
    task automatic test_zero_divisor();
        write_all_cal({16'h0000, 16'h8000, 16'h0000}, {16'h0000, 16'd16384, 16'd100},
                      {TYP_P6, TYP_P5, TYP_P4}, {TYP_P9, TYP_P8, TYP_P7});
        // fine temperature -1969152 makes the divisor term exactly zero
        send_sample(KIND_TEMP, 20'd984576);
        send_sample(KIND_PRESS, 20'd415148);
        send_sample(KIND_TEMP, 20'd984575);
        send_sample(KIND_PRESS, 20'd415148);
        wait_idle();
        write_cal(CFG_PRESS_A, {TYP_P3, TYP_P2, 16'h0000});
        send_sample(KIND_PRESS, 20'd300000);
        wait_idle();
    endtask

    function automatic logic [RAW_W-1:0] pick_raw(logic kind);
        if ($urandom_range(3) == 0)
            return RAW_W'($urandom);
        return (kind == KIND_TEMP) ? RAW_W'($urandom_range(440000, 600000))
                                   : RAW_W'($urandom_range(250000, 560000));
    endfunction

    // calibration phases, each a run of temperature-then-pressure bursts mixed with random single samples
    task automatic test_random_phases();
        int phase, sent, burst, k, mode;
        for (phase = 0; phase < 18; phase++) begin
            wait_idle();
            mode = phase % 6;
            ready_steady = (phase % 5 == 4);
            if (mode == 5)
                write_all_cal(CAL_W'({$urandom, $urandom}), CAL_W'({$urandom, $urandom}),
                              CAL_W'({$urandom, $urandom}), CAL_W'({$urandom, $urandom}));
            else if (mode == 4)
                load_typical_cal(2000);
            else
                load_typical_cal(mode * 40);
            sent = 0;
            while (sent < 105) begin
                if ($urandom_range(9) == 0) begin
                    send_sample(logic'($urandom), RAW_W'($urandom));
                    sent++;
                end else begin
                    send_sample(KIND_TEMP, pick_raw(KIND_TEMP));
                    burst = $urandom_range(1, 5);
                    for (k = 0; k < burst; k++)
                        send_sample(KIND_PRESS, pick_raw(KIND_PRESS));
                    sent += burst + 1;
                end
            end
        end
        ready_steady = 1'b0;
        wait_idle();
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!ready_steady && $urandom_range(5) == 0)
                stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 3);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d value=%0d", $time,
                         m_data.result_kind, m_data.value);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data.result_kind !== exp_r.result_kind) begin
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             exp_r.result_kind, m_data.result_kind);
                    error_count++;
                end
                if (m_data.value !== exp_r.value) begin
                    $display("%0t: value expected %0d actual %0d", $time,
                             exp_r.value, m_data.value);
                    error_count++;
                end
                if (m_data.divide_error !== exp_r.divide_error) begin
                    $display("%0t: divide_error expected %0d actual %0d", $time,
                             exp_r.divide_error, m_data.divide_error);
                    error_count++;
                end
                if (m_data.saturated !== exp_r.saturated) begin
                    $display("%0t: saturated expected %0d actual %0d", $time,
                             exp_r.saturated, m_data.saturated);
                    error_count++;
                end
                if (exp_r.result_kind == KIND_TEMP)
                    temp_seen++;
                else
                    press_seen++;
                if (exp_r.divide_error)
                    div_err_seen++;
                if (exp_r.saturated)
                    sat_seen++;
            end
        end
    end

    // test sequence
    initial begin
        int i;
        for (i = 0; i < CFG_REGS; i++)
            cal_regs[i] = '0;
        fine_temp = '0;
        error_count = 0;
        ready_steady = 1'b0;
        stall_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_after_reset();
        test_extremes();
        test_zero_divisor();
        test_random_phases();
        repeat (400) @(posedge aclk);
        $display("covered %0d temperature and %0d pressure results", temp_seen, press_seen);
        $display("of which %0d divide errors and %0d saturated", div_err_seen, sat_seen);
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #10000000;
        $display("timeout with %0d results pending", expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
